/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the prime test block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define DPT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define DPT_ASSERT(lbl, clk, rst_n, prop)
`define DPT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/dpt_pkg.sv */
// Package: constants, tables and state type of the prime test block.
package dpt_pkg;

  localparam int DefNumWidth = 63;
  localparam int BaseCount = 12;
  localparam int IdxW = $clog2(BaseCount + 1);
  localparam int BaseW = 6;
  localparam logic [63:0] PseudoException = 64'd3215031751;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCREEN,
    ST_SPLIT,
    ST_ROUND,
    ST_POW,
    ST_MUL_ACC,
    ST_SQ_START,
    ST_MUL_SQ,
    ST_TEST,
    ST_SQR,
    ST_SQR_WAIT,
    ST_DONE
  } dpt_state_e;

  function automatic logic [BaseW-1:0] base_of(input logic [IdxW-1:0] idx);
    logic [BaseW-1:0] b;
    unique case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

  // zero means no bound for that round
  function automatic logic [63:0] bound_of(input logic [IdxW-1:0] idx);
    logic [63:0] v;
    unique case (idx)
      4'd0:    v = 64'd4;
      4'd2:    v = 64'd1373653;
      4'd3:    v = 64'd25326001;
      4'd4:    v = 64'd25000000000;
      4'd5:    v = 64'd2152302898747;
      4'd6:    v = 64'd3474749660383;
      4'd7:    v = 64'd341550071728321;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/dpt_modmul.sv */
// Bit-serial double-and-add modular multiplier, one multiplier bit per cycle.
module dpt_modmul #(
  parameter int NUM_WIDTH = dpt_pkg::DefNumWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] a_i,
  input  logic [NUM_WIDTH-1:0] b_i,
  input  logic [NUM_WIDTH-1:0] m_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [NUM_WIDTH-1:0] res_o
);
  import dpt_pkg::*;

  localparam int W = NUM_WIDTH;

  logic         busy_q, busy_d;
  logic [W-1:0] a_q, a_d;
  logic [W-1:0] b_q, b_d;
  logic [W-1:0] acc_q, acc_d;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  assign done_o = busy_q && (b_q == '0);
  assign busy_o = busy_q;
  assign res_o  = acc_q;

  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_d = add_mod(acc_q, a_q, m_i);
        end
        a_d = add_mod(a_q, a_q, m_i);
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

endmodule

/* hw/rtl/dpt_core.sv */
// Sequencer: screening, strong probable prime rounds and exponentiation.
`include "assert_macros.svh"

module dpt_core #(
  parameter int NUM_WIDTH = dpt_pkg::DefNumWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] n_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output logic                 res_prime_o,
  input  logic                 res_ready_i,
  output logic                 mm_start_o,
  output logic [NUM_WIDTH-1:0] mm_a_o,
  output logic [NUM_WIDTH-1:0] mm_b_o,
  output logic [NUM_WIDTH-1:0] mm_m_o,
  input  logic                 mm_busy_i,
  input  logic                 mm_done_i,
  input  logic [NUM_WIDTH-1:0] mm_res_i
);
  import dpt_pkg::*;

  localparam int W  = NUM_WIDTH;
  localparam int SW = $clog2(NUM_WIDTH);

  dpt_state_e    state_q, state_d;
  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  d_q, d_d;
  logic [SW-1:0] s_q, s_d;
  logic [SW-1:0] k_q, k_d;
  logic [IdxW-1:0] i_q, i_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  b_q, b_d;
  logic [W-1:0]  e_q, e_d;
  logic          prime_q, prime_d;
  logic [W-1:0]  n_m1;
  logic [63:0]   n_ext;
  logic [63:0]   bnd;

  assign n_m1   = n_q - W'(1);
  assign n_ext  = 64'(n_q);
  assign bnd    = bound_of(i_q);
  assign mm_m_o = n_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_prime_o = prime_q;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    d_d        = d_q;
    s_d        = s_q;
    k_d        = k_q;
    i_d        = i_q;
    acc_d      = acc_q;
    b_d        = b_q;
    e_d        = e_q;
    prime_d    = prime_q;
    mm_start_o = 1'b0;
    mm_a_o     = acc_q;
    mm_b_o     = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_d     = n_i;
          state_d = ST_SCREEN;
        end
      end
      ST_SCREEN: begin
        if (n_ext < 64'd2 || n_ext == PseudoException) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (n_ext < 64'd4) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          d_d     = n_m1;
          s_d     = '0;
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          s_d = s_q + SW'(1);
        end else begin
          i_d     = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (i_q == IdxW'(BaseCount)) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else if (bnd != '0 && n_ext < bnd) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          acc_d   = W'(1);
          b_d     = W'(base_of(i_q));
          e_d     = d_q;
          state_d = ST_POW;
        end
      end
      ST_POW: begin
        mm_a_o = acc_q;
        mm_b_o = b_q;
        if (e_q == '0) begin
          state_d = ST_TEST;
        end else if (e_q[0]) begin
          mm_start_o = 1'b1;
          state_d    = ST_MUL_ACC;
        end else begin
          state_d = ST_SQ_START;
        end
      end
      ST_MUL_ACC: begin
        if (mm_done_i) begin
          acc_d   = mm_res_i;
          state_d = ST_SQ_START;
        end
      end
      ST_SQ_START: begin
        mm_a_o     = b_q;
        mm_b_o     = b_q;
        mm_start_o = 1'b1;
        state_d    = ST_MUL_SQ;
      end
      ST_MUL_SQ: begin
        if (mm_done_i) begin
          b_d     = mm_res_i;
          e_d     = e_q >> 1;
          state_d = ST_POW;
        end
      end
      ST_TEST: begin
        if (acc_q == W'(1) || acc_q == n_m1) begin
          i_d     = i_q + IdxW'(1);
          state_d = ST_ROUND;
        end else begin
          k_d     = SW'(1);
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (k_q < s_q) begin
          mm_start_o = 1'b1;
          state_d    = ST_SQR_WAIT;
        end else begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_SQR_WAIT: begin
        if (mm_done_i) begin
          acc_d = mm_res_i;
          if (mm_res_i == n_m1) begin
            i_d     = i_q + IdxW'(1);
            state_d = ST_ROUND;
          end else begin
            k_d     = k_q + SW'(1);
            state_d = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    s_q     <= s_d;
    k_q     <= k_d;
    i_q     <= i_d;
    acc_q   <= acc_d;
    b_q     <= b_d;
    e_q     <= e_d;
    prime_q <= prime_d;
  end

  `DPT_ASSERT_NEVER(a_mm_start_busy, clk_i, rst_ni, mm_start_o && mm_busy_i)
  `DPT_ASSERT(a_split_nonzero, clk_i, rst_ni, (state_q == ST_SPLIT) |-> (d_q != '0))
  `DPT_ASSERT(a_test_reduced, clk_i, rst_ni, (state_q == ST_TEST) |-> (acc_q < n_q))
  `DPT_ASSERT(a_prime_ge2, clk_i, rst_ni, (res_valid_o && res_prime_o) |-> (n_q > W'(1)))

endmodule

/* hw/rtl/deterministic_prime_test.sv */
// Deterministic Miller-Rabin prime test: one candidate in, one prime flag out.
// One candidate is tested at a time; s_axis_tready_o is high while the sequencer is idle,
// and a finished flag waits in the output register. A test runs screening, one split
// step per trailing zero of n-1, and then up to twelve rounds. Each round is a
// square-and-multiply exponentiation plus up to s-1 squarings, all on one shared
// bit-serial modular multiplier. A round needs at most about 124 products.
module deterministic_prime_test #(
  parameter int NUM_WIDTH = dpt_pkg::DefNumWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: candidate [NUM_WIDTH-1:0], zero fill above
  input  logic [((NUM_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: is_prime [0], zero fill above
  output logic [7:0]                         m_axis_tdata_o
);
  import dpt_pkg::*;

  logic                 core_busy;
  logic                 core_start;
  logic                 res_valid, res_prime, res_ready;
  logic                 mm_start, mm_busy, mm_done;
  logic [NUM_WIDTH-1:0] mm_a, mm_b, mm_m, mm_res;
  logic                 out_valid_q, out_valid_d;
  logic                 out_prime_q, out_prime_d;

  assign s_axis_tready_o = !core_busy;
  assign core_start      = s_axis_tvalid_i && !core_busy;
  assign res_ready       = !out_valid_q || m_axis_tready_i;

  dpt_core #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (core_start),
    .n_i        (s_axis_tdata_i[NUM_WIDTH-1:0]),
    .busy_o     (core_busy),
    .res_valid_o(res_valid),
    .res_prime_o(res_prime),
    .res_ready_i(res_ready),
    .mm_start_o (mm_start),
    .mm_a_o     (mm_a),
    .mm_b_o     (mm_b),
    .mm_m_o     (mm_m),
    .mm_busy_i  (mm_busy),
    .mm_done_i  (mm_done),
    .mm_res_i   (mm_res)
  );

  dpt_modmul #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (mm_m),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_prime_d = res_prime;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_prime_q <= out_prime_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_prime_q};

endmodule

/* dv/dpt_checker.sv */
`timescale 1ns / 100ps
// Checker for the prime test block: predicts the prime flag of each candidate and compares.
module dpt_checker #(
  parameter int NUM_WIDTH = dpt_pkg::DefNumWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  input  logic                                 s_axis_tready_i,
  // tdata: candidate [NUM_WIDTH-1:0], zero fill above
  input  logic [((NUM_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata_i,
  input  logic                                 m_axis_tvalid_i,
  input  logic                                 m_axis_tready_i,
  // tdata: is_prime [0], zero fill above
  input  logic [7:0]                           m_axis_tdata_i,
  output int                                   mismatches_o,
  output int                                   outstanding_o
);

  localparam int RoundCount = 12;
  localparam logic [63:0] SpspException = 64'd3215031751;
  localparam logic [63:0] CandMask = (64'd1 << NUM_WIDTH) - 64'd1;

  localparam logic [63:0] RoundBase [RoundCount] = '{
    64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
    64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
  };

  // n below the entry when that round is about to start is proven prime; zero: no bound
  localparam logic [63:0] ProvenBelow [RoundCount] = '{
    64'd4, 64'd0, 64'd1373653, 64'd25326001, 64'd25000000000, 64'd2152302898747,
    64'd3474749660383, 64'd341550071728321, 64'd0, 64'd0, 64'd0, 64'd0
  };

  typedef struct packed {
    logic [63:0] candidate;
    logic        is_prime;
  } prime_verdict_t;

  prime_verdict_t verdict_q [$];
  prime_verdict_t oldest;
  int             mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // operands below m < 2^63, so the sum fits in 64 bits
  function automatic logic [63:0] mod_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [63:0] s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd0;
    while (b != 64'd0) begin
      if (b[0]) acc = mod_sum(acc, a, m);
      a = mod_sum(a, a, m);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] mod_power(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] m);
    logic [63:0] acc;
    acc = (m == 64'd1) ? 64'd0 : 64'd1;
    b = b % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mod_product(acc, b, m);
      b = mod_product(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic strong_round(input logic [63:0] n, input logic [63:0] a);
    logic [63:0] d;
    logic [63:0] x;
    int          s;
    d = n - 64'd1;
    s = 0;
    while (!d[0] && d != 64'd0) begin
      d = d >> 1;
      s++;
    end
    x = mod_power(a, d, n);
    if (x == 64'd1 || x == n - 64'd1) return 1'b1;
    for (int k = 1; k < s; k++) begin
      x = mod_product(x, x, n);
      if (x == n - 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic predict_prime(input logic [63:0] n);
    if (n < 64'd2 || n == SpspException) return 1'b0;
    for (int i = 0; i < RoundCount; i++) begin
      if (n < ProvenBelow[i]) return 1'b1;
      if (!strong_round(n, RoundBase[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result is_prime=%0b with no candidate waiting",
                                    m_axis_tdata_i[0]));
        end else begin
          oldest = verdict_q.pop_front();
          if (m_axis_tdata_i[0] !== oldest.is_prime)
            report_mismatch($sformatf("candidate %0d: is_prime=%0b, expected %0b",
                                      oldest.candidate, m_axis_tdata_i[0], oldest.is_prime));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        oldest.candidate = 64'(s_axis_tdata_i) & CandMask;
        oldest.is_prime  = predict_prime(oldest.candidate);
        verdict_q.push_back(oldest);
      end
      outstanding_o <= verdict_q.size();
    end else begin
      outstanding_o <= 0;
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the prime test block: clock, reset, candidate stimulus and verdict.
module tb_top;

  localparam int NumWidth = dpt_pkg::DefNumWidth;
  localparam int DataW = ((NumWidth + 7) / 8) * 8;
  localparam int HoldCycles = 3000;
  localparam int WatchdogLimit = 600000;
  localparam int TailCycles = 200;
  localparam int CornerCount = 22;

  // small values, pseudoprimes at each bound, the exception, large primes and extremes;
  // the last two carry the fill bit, which must be ignored
  localparam logic [63:0] CornerWords [CornerCount] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd561, 64'd2047,
    64'd1373653, 64'd25326001, 64'd3215031751, 64'd4294967291, 64'd2152302898747,
    64'd3474749660383, 64'd341550071728321, 64'd3825123056546413051,
    64'd2305843009213693951, 64'd4611686018427387904, 64'd9223372036854775807,
    64'h8000_0000_0000_0007, 64'h8000_0000_0000_0000
  };

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [7:0]       m_axis_tdata_o;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 18;
  int rx_idle_pct = 85;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;

  deterministic_prime_test #(
    .NUM_WIDTH(NumWidth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  dpt_checker #(
    .NUM_WIDTH(NumWidth)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL deterministic_prime_test");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side; a hold request keeps tready low for a long stretch
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // first odd prime at or above start, by trial division
  function automatic longint unsigned next_prime(input longint unsigned start);
    longint unsigned c;
    bit              composite;
    c = (start < 3) ? 3 : (start | 1);
    do begin
      composite = 1'b0;
      for (longint unsigned f = 3; f * f <= c; f += 2) begin
        if (c % f == 0) begin
          composite = 1'b1;
          break;
        end
      end
      if (composite) c += 2;
    end while (composite);
    return c;
  endfunction

  // mostly small and mid-size candidates; full width only now and then
  function automatic logic [63:0] pick_candidate();
    logic [63:0] word;
    int          kind;
    kind = $urandom_range(99);
    word = {$urandom, $urandom};
    if (kind < 30)
      word = 64'($urandom_range(4095));
    else if (kind < 50)
      word = next_prime($urandom_range(1 << 22));
    else if (kind < 60)
      word = next_prime($urandom_range(32'h3fff_ffff));
    else if (kind < 72)
      word = next_prime($urandom_range(65535)) * next_prime($urandom_range(65535));
    else if (kind < 90)
      word = {1'b0, word[62:0]} >> $urandom_range(30, 16);
    return word;
  endfunction

  task automatic push_candidate(input logic [63:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DataW'(word);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CornerWords[i]) push_candidate(CornerWords[i]);
    wait_results();

    // result side blocked while candidates keep coming
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (6) push_candidate(64'($urandom_range(4095)));
    wait_results();

    tx_idle_pct = 85;
    rx_idle_pct = 18;
    repeat (36) push_candidate(pick_candidate());
    wait_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (36) push_candidate(pick_candidate());
    wait_results();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS deterministic_prime_test");
    end else begin
      $display("FAIL deterministic_prime_test");
    end
    $finish;
  end

endmodule
